FILE: rtl/trld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trld_pkg
// Types and constants shared by the run-length line decoder files.
// ----------------------------------------------------------------------------
package trld_pkg;

   localparam int PIXEL_W     = 32;
   localparam int REPEAT_W    = 8;
   localparam int LINE_W      = 16;
   localparam int LINE_CNT_W  = 17;
   localparam int BPP_W       = 3;
   localparam int BYTE_IDX_W  = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [7:0] RUN_FLAG_MASK = 8'h80;
   localparam logic [7:0] COUNT_MASK    = 8'h7F;

   localparam logic [BPP_W-1:0]  BPP_RESET  = 3'd3;
   localparam logic [LINE_W-1:0] LINE_RESET = 16'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_PIXELS     = 2'd1;

   typedef struct packed {
      logic [PIXEL_W-1:0]  pixel;
      logic [REPEAT_W-1:0] repeat_res;
      logic                line_end;
      logic                overrun;
   } rsp_payload_type;

endpackage
`default_nettype wire

FILE: rtl/trld_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trld_req_if
// Byte stream channel into the line decoder.
// ----------------------------------------------------------------------------
interface trld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/trld_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trld_rsp_if
// Pixel channel out of the line decoder.
// ----------------------------------------------------------------------------
interface trld_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel;
   logic [7:0]  repeat_res;
   logic        line_end;
   logic        overrun;

   modport source (output valid, output pixel, output repeat_res, output line_end,
                   output overrun, input ready);
   modport sink   (input valid, input pixel, input repeat_res, input line_end,
                   input overrun, output ready);
endinterface
`default_nettype wire

FILE: rtl/trld_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trld_out_buf
// Two-entry output buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module trld_out_buf (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output      logic                     in_ready,
   input  wire trld_pkg::rsp_payload_type in_data,
   output      logic                     out_valid,
   input  wire logic                     out_ready,
   output      trld_pkg::rsp_payload_type out_data
);
   import trld_pkg::*;

   logic            main_valid_ff, main_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type main_ff, main_in;
   rsp_payload_type skid_ff, skid_in;
   logic            take;

   assign take      = main_valid_ff && out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (in_valid) begin
            main_in = in_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without output entry");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> in_ready)
      else $error("transaction pushed into full buffer");

   a_main_holds: assert property (@(posedge clock) disable iff (reset)
      (main_valid_ff && !out_ready) |=> (main_valid_ff && $stable(main_ff)))
      else $error("stalled output entry changed");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !take) |=> (skid_valid_ff && $stable(skid_ff)))
      else $error("skid entry lost");

endmodule
`default_nettype wire

FILE: rtl/tga_rle_line_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tga_rle_line_decoder_unit
// Run-length packet decoder: parses headers, assembles pixels, tracks lines.
// ----------------------------------------------------------------------------
// Usage:
//   req_if carries one coded byte per transaction (header or pixel data).
//   rsp_if carries one transaction per completed pixel: the pixel, its repeat
//   count, a line end flag and an overrun flag. Runs are not expanded.
//   csr_* writes bytes_per_pixel (index 0) and line_pixels (index 1); other
//   indexes are ignored. Write only while the block is idle.
// Throughput: one byte per cycle while req_if.ready is high. Headers and non-final pixel bytes produce
//   no transaction.
// Output: a pixel reaches rsp_if from the output register once its last byte is
//   taken; while rsp_if stalls, it may wait in the skid register first.
// Stall: a two-entry output buffer (output and skid register) keeps req_if
//   ready while one result waits; req_if.ready drops only while both
//   entries are full, and returns the cycle after rsp_if takes one.
// Reset: decoder expects a header, line count is zero, bytes_per_pixel is 3,
//   line_pixels is 1, and the output buffer is empty.
// ----------------------------------------------------------------------------
module tga_rle_line_decoder_unit #(
   parameter int MAX_BYTES_PER_PIXEL = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   trld_req_if.sink         req_if,
   trld_rsp_if.source       rsp_if,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);
   import trld_pkg::*;

   localparam int PART_W = 8 * MAX_BYTES_PER_PIXEL;
   localparam logic [BPP_W-1:0] MAX_BPP = BPP_W'(MAX_BYTES_PER_PIXEL);

   logic [BPP_W-1:0]      bpp_ff;
   logic [LINE_W-1:0]     line_pixels_ff;

   logic                  in_pixel_data_ff, in_pixel_data_in;
   logic                  packet_is_run_ff, packet_is_run_in;
   logic [REPEAT_W-1:0]   packet_left_ff, packet_left_in;
   logic [BYTE_IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [PART_W-1:0]     partial_pixel_ff, partial_pixel_in;
   logic [LINE_CNT_W-1:0] line_count_ff, line_count_in;

   logic                  accept;
   logic [7:0]            data;
   logic [BPP_W-1:0]      eff_bpp;
   logic [LINE_W-1:0]     width;
   logic [REPEAT_W-1:0]   left_fix;
   logic [REPEAT_W-1:0]   rep;
   logic [REPEAT_W-1:0]   left_next;
   logic [LINE_CNT_W-1:0] after;
   logic [PIXEL_W-1:0]    pix_word;
   logic                  more_bytes;
   logic                  res_valid;
   logic                  buf_ready;
   rsp_payload_type       res;
   rsp_payload_type       out_data;

   assign data   = req_if.data_byte;
   assign accept = req_if.valid && buf_ready;
   assign req_if.ready = buf_ready;

   assign eff_bpp = (bpp_ff == '0) ? BPP_W'(1) :
                    (bpp_ff > MAX_BPP) ? MAX_BPP : bpp_ff;
   assign width   = (line_pixels_ff == '0) ? LINE_W'(1) : line_pixels_ff;

   assign more_bytes = (BPP_W'(byte_index_ff) + BPP_W'(1)) < eff_bpp;
   assign pix_word   = PIXEL_W'(partial_pixel_ff) |
                       (PIXEL_W'(data) << {byte_index_ff, 3'b000});
   assign left_fix   = (packet_left_ff == '0) ? REPEAT_W'(1) : packet_left_ff;
   assign rep        = packet_is_run_ff ? left_fix : REPEAT_W'(1);
   assign after      = line_count_ff + LINE_CNT_W'(rep);
   assign left_next  = left_fix - rep;

   always_comb begin
      in_pixel_data_in = in_pixel_data_ff;
      packet_is_run_in = packet_is_run_ff;
      packet_left_in   = packet_left_ff;
      byte_index_in    = byte_index_ff;
      partial_pixel_in = partial_pixel_ff;
      line_count_in    = line_count_ff;
      res_valid        = 1'b0;
      res.pixel        = pix_word;
      res.repeat_res   = rep;
      res.overrun      = after > LINE_CNT_W'(width);
      res.line_end     = 1'b0;
      if (accept) begin
         if (!in_pixel_data_ff) begin
            packet_is_run_in = (data & RUN_FLAG_MASK) != '0;
            packet_left_in   = (data & COUNT_MASK) + REPEAT_W'(1);
            in_pixel_data_in = 1'b1;
            byte_index_in    = '0;
            partial_pixel_in = '0;
         end else if (more_bytes) begin
            for (int k = 0; k < MAX_BYTES_PER_PIXEL; k++) begin
               if (byte_index_ff == BYTE_IDX_W'(k)) begin
                  partial_pixel_in[8*k +: 8] = data;
               end
            end
            byte_index_in = byte_index_ff + BYTE_IDX_W'(1);
         end else begin
            res_valid        = 1'b1;
            byte_index_in    = '0;
            partial_pixel_in = '0;
            packet_left_in   = left_next;
            line_count_in    = after;
            if (left_next == '0) begin
               in_pixel_data_in = 1'b0;
               if (after >= LINE_CNT_W'(width)) begin
                  res.line_end  = 1'b1;
                  line_count_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff           <= BPP_RESET;
         line_pixels_ff   <= LINE_RESET;
         in_pixel_data_ff <= 1'b0;
         packet_is_run_ff <= 1'b0;
         packet_left_ff   <= '0;
         byte_index_ff    <= '0;
         partial_pixel_ff <= '0;
         line_count_ff    <= '0;
      end else begin
         in_pixel_data_ff <= in_pixel_data_in;
         packet_is_run_ff <= packet_is_run_in;
         packet_left_ff   <= packet_left_in;
         byte_index_ff    <= byte_index_in;
         partial_pixel_ff <= partial_pixel_in;
         line_count_ff    <= line_count_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_BYTES_PER_PIXEL: bpp_ff         <= csr_wdata[BPP_W-1:0];
               CSR_LINE_PIXELS:     line_pixels_ff <= csr_wdata[LINE_W-1:0];
               default: ;
            endcase
         end
      end
   end

   trld_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (buf_ready),
      .in_data   (res),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (out_data)
   );

   assign rsp_if.pixel      = out_data.pixel;
   assign rsp_if.repeat_res = out_data.repeat_res;
   assign rsp_if.line_end   = out_data.line_end;
   assign rsp_if.overrun    = out_data.overrun;

   a_byte_index_bound: assert property (@(posedge clock) disable iff (reset)
      (BPP_W'(byte_index_ff) < MAX_BPP))
      else $error("byte index past pixel size");

   a_header_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && !in_pixel_data_ff) |=> (in_pixel_data_ff && packet_left_ff != '0
         && byte_index_ff == '0))
      else $error("header did not open a packet");

   a_line_end_resets: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.line_end) |=> (line_count_ff == '0 && !in_pixel_data_ff))
      else $error("line end did not restart the line");

endmodule
`default_nettype wire
